FILE: sv/vni_digit_pair_transcoder_defines.svh
// ----------------------------------------------------------------------------
// vni_digit_pair_transcoder_defines.svh
// Assertion macros shared by the transcoder RTL.
// ----------------------------------------------------------------------------
`ifndef VNI_DIGIT_PAIR_TRANSCODER_DEFINES_SVH
`define VNI_DIGIT_PAIR_TRANSCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define VDPT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define VDPT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define VDPT_ASSERT_IMP(lbl, ante, cons)
`define VDPT_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

FILE: sv/vdpt_pkg.sv
// ----------------------------------------------------------------------------
// vdpt_pkg
// Types, character codes and the pair table of the VNI digit-pair transcoder.
// ----------------------------------------------------------------------------
package vdpt_pkg;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
	} out_item_t;

	// Outcome of one request: up to two output bytes and the next held byte.
	typedef struct packed {
		logic [1:0] cnt;
		out_item_t  r0;
		out_item_t  r1;
		logic       hold_v;
		logic [7:0] hold_b;
	} step_t;

	localparam logic [7:0] CH_A   = 8'h61;
	localparam logic [7:0] CH_E   = 8'h65;
	localparam logic [7:0] CH_I   = 8'h69;
	localparam logic [7:0] CH_O   = 8'h6F;
	localparam logic [7:0] CH_U   = 8'h75;
	localparam logic [7:0] CH_Y   = 8'h79;
	localparam logic [7:0] CH_D   = 8'h64;
	localparam logic [7:0] CH_UD  = 8'h44;
	localparam logic [7:0] DIG_1  = 8'h31;
	localparam logic [7:0] DIG_5  = 8'h35;
	localparam logic [7:0] DIG_6  = 8'h36;
	localparam logic [7:0] DIG_7  = 8'h37;
	localparam logic [7:0] DIG_8  = 8'h38;
	localparam logic [7:0] DIG_9  = 8'h39;

	localparam logic [7:0] MK_A8  = 8'd128;
	localparam logic [7:0] MK_A6  = 8'd134;
	localparam logic [7:0] MK_E6  = 8'd140;
	localparam logic [7:0] MK_O7  = 8'd146;
	localparam logic [7:0] MK_O6  = 8'd152;
	localparam logic [7:0] MK_U7  = 8'd158;
	localparam logic [7:0] CD_D9  = 8'd249;
	localparam logic [7:0] CD_UD9 = 8'd250;
	localparam logic [7:0] A_TONE = 8'd164;
	localparam logic [7:0] E_TONE = 8'd169;
	localparam logic [7:0] U_TONE = 8'd210;
	localparam logic [7:0] NO_PAIR = 8'd0;

	function automatic logic is_mark(input logic [7:0] b);
		return b inside {MK_A8, MK_A6, MK_E6, MK_O7, MK_O6, MK_U7};
	endfunction

	function automatic logic may_start(input logic [7:0] b);
		return (b inside {CH_A, CH_E, CH_I, CH_O, CH_U, CH_Y, CH_D, CH_UD}) || is_mark(b);
	endfunction

	function automatic logic [7:0] i_tone(input logic [2:0] t);
		case (t)
			3'd0: return 8'd174;
			3'd1: return 8'd175;
			3'd2: return 8'd181;
			3'd3: return 8'd182;
			3'd4: return 8'd183;
			default: return NO_PAIR;
		endcase
	endfunction

	function automatic logic [7:0] o_tone(input logic [2:0] t);
		case (t)
			3'd0: return 8'd184;
			3'd1: return 8'd190;
			3'd2: return 8'd198;
			3'd3: return 8'd199;
			3'd4: return 8'd208;
			default: return NO_PAIR;
		endcase
	endfunction

	function automatic logic [7:0] y_tone(input logic [2:0] t);
		case (t)
			3'd0: return 8'd215;
			3'd1: return 8'd216;
			3'd2: return 8'd221;
			3'd3: return 8'd222;
			3'd4: return 8'd248;
			default: return NO_PAIR;
		endcase
	endfunction

	// Code of the pair (f, s); NO_PAIR when the pair is not in the table.
	function automatic logic [7:0] pair_code(input logic [7:0] f, input logic [7:0] s);
		logic       tone;
		logic [7:0] d;
		logic [7:0] tw;
		logic [7:0] res;
		tone = (s >= DIG_1) && (s <= DIG_5);
		d    = s - DIG_1;
		tw   = tone ? {5'd0, d[2:0]} : 8'd0;
		res  = NO_PAIR;
		if (is_mark(f)) begin
			res = tone ? (f + tw + 8'd1) : NO_PAIR;
		end else begin
			case (f)
				CH_A: begin
					if (s == DIG_8) res = MK_A8;
					else if (s == DIG_6) res = MK_A6;
					else if (tone) res = A_TONE + tw;
				end
				CH_E: begin
					if (s == DIG_6) res = MK_E6;
					else if (tone) res = E_TONE + tw;
				end
				CH_I: begin
					if (tone) res = i_tone(d[2:0]);
				end
				CH_O: begin
					if (s == DIG_7) res = MK_O7;
					else if (s == DIG_6) res = MK_O6;
					else if (tone) res = o_tone(d[2:0]);
				end
				CH_U: begin
					if (s == DIG_7) res = MK_U7;
					else if (tone) res = U_TONE + tw;
				end
				CH_Y: begin
					if (tone) res = y_tone(d[2:0]);
				end
				CH_D: begin
					if (s == DIG_9) res = CD_D9;
				end
				CH_UD: begin
					if (s == DIG_9) res = CD_UD9;
				end
				default: begin
					res = NO_PAIR;
				end
			endcase
		end
		return res;
	endfunction

endpackage

FILE: sv/vni_digit_pair_transcoder.sv
// ----------------------------------------------------------------------------
// vni_digit_pair_transcoder
// Replaces VNI letter+digit sequences in a byte stream with font codes.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------------------
//  input    | in_valid / in_ready   | in_data  (in_byte, end_of_text)
//  output   | out_valid / out_ready | out_data (out_byte, last)
//
// One request per cycle is taken while the result queue holds at most one
// byte; the table lookup against the held byte is done in the accept cycle.
// A request yields zero, one or two bytes; the output sends at most one
// per cycle, so a two-byte request drops in_ready for the next cycle even
// when the output never stalls.
// Reset clears the held byte and empties the queue; no clearing pass.
// in_ready comes from the queue count only, never from out_ready.
// ----------------------------------------------------------------------------
`include "vni_digit_pair_transcoder_defines.svh"

module vni_digit_pair_transcoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  vdpt_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output vdpt_pkg::out_item_t out_data
);
	import vdpt_pkg::*;

	logic       held_v_q;
	logic [7:0] held_b_q;
	logic       accept;
	logic       room2;
	step_t      step;

	assign accept   = in_valid && in_ready;
	assign in_ready = room2;

	vdpt_decode u_decode (
		.held_v (held_v_q),
		.held_b (held_b_q),
		.item   (in_data),
		.step   (step)
	);

	vdpt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (accept ? step.cnt : 2'd0),
		.push0     (step.r0),
		.push1     (step.r1),
		.room2     (room2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
			held_b_q <= 8'd0;
		end else if (accept) begin
			held_v_q <= step.hold_v;
			held_b_q <= step.hold_b;
		end
	end

	`VDPT_ASSERT_NXT(a_eot_flush, accept && in_data.end_of_text, !held_v_q)
	`VDPT_ASSERT_IMP(a_stall_has_data, !in_ready, out_valid)
	`VDPT_ASSERT_IMP(a_held_starts, held_v_q, may_start(held_b_q))

endmodule

FILE: sv/vdpt_decode.sv
// ----------------------------------------------------------------------------
// vdpt_decode
// Pairs the held byte with the incoming byte and decides what is emitted
// and what is held next.
// ----------------------------------------------------------------------------
module vdpt_decode (
	input  logic              held_v,
	input  logic [7:0]        held_b,
	input  vdpt_pkg::in_item_t item,
	output vdpt_pkg::step_t    step
);
	import vdpt_pkg::*;

	logic [7:0] code;
	logic       paired;
	logic       new_held;

	assign code     = pair_code(held_b, item.in_byte);
	assign paired   = held_v && (code != NO_PAIR);
	assign new_held = may_start(item.in_byte) && !item.end_of_text;

	always_comb begin
		step        = '0;
		step.hold_b = 8'd0;
		if (paired) begin
			if (is_mark(code) && !item.end_of_text) begin
				// A marked vowel may still take a tone digit.
				step.hold_v = 1'b1;
				step.hold_b = code;
			end else begin
				step.cnt = 2'd1;
				step.r0  = '{out_byte: code, last: item.end_of_text};
			end
		end else if (held_v) begin
			step.r0 = '{out_byte: held_b, last: 1'b0};
			if (new_held) begin
				step.cnt    = 2'd1;
				step.hold_v = 1'b1;
				step.hold_b = item.in_byte;
			end else begin
				step.cnt = 2'd2;
				step.r1  = '{out_byte: item.in_byte, last: item.end_of_text};
			end
		end else if (new_held) begin
			step.hold_v = 1'b1;
			step.hold_b = item.in_byte;
		end else begin
			step.cnt = 2'd1;
			step.r0  = '{out_byte: item.in_byte, last: item.end_of_text};
		end
	end

endmodule

FILE: sv/vdpt_outq.sv
// ----------------------------------------------------------------------------
// vdpt_outq
// Three-entry queue; takes up to two bytes per cycle, sends one if out_ready.
// ----------------------------------------------------------------------------
`include "vni_digit_pair_transcoder_defines.svh"

module vdpt_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_cnt,
	input  vdpt_pkg::out_item_t push0,
	input  vdpt_pkg::out_item_t push1,
	output logic                room2,
	output logic                out_valid,
	input  logic                out_ready,
	output vdpt_pkg::out_item_t out_data
);
	import vdpt_pkg::*;

	out_item_t  q_q [3];
	out_item_t  q_nx [3];
	logic [1:0] cnt_q;
	logic       pop;
	logic [1:0] base;

	assign pop       = (cnt_q != 2'd0) && out_ready;
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = q_q[0];
	assign room2     = (cnt_q <= 2'd1);
	assign base      = cnt_q - {1'b0, pop};

	always_comb begin
		q_nx[0] = pop ? q_q[1] : q_q[0];
		q_nx[1] = pop ? q_q[2] : q_q[1];
		q_nx[2] = q_q[2];
		for (int i = 0; i < 3; i++) begin
			if ((push_cnt != 2'd0) && (base == 2'(i))) q_nx[i] = push0;
			if ((push_cnt == 2'd2) && (base + 2'd1 == 2'(i))) q_nx[i] = push1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			q_q[i] <= q_nx[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= base + push_cnt;
		end
	end

	`VDPT_ASSERT_IMP(a_push_fits, push_cnt != 2'd0, cnt_q <= 2'd1)
	`VDPT_ASSERT_NXT(a_cnt_track, 1'b1,
		cnt_q == $past(cnt_q) - {1'b0, $past(pop)} + $past(push_cnt))
	`VDPT_ASSERT_IMP(a_push_max, 1'b1, push_cnt != 2'd3)

endmodule
